FILE: src/imu_sample_converter_defines.svh
// assertion macros for the imu sample converter
// no dependencies
`ifndef IMU_SAMPLE_CONVERTER_DEFINES_SVH
`define IMU_SAMPLE_CONVERTER_DEFINES_SVH
// implication checked every cycle outside reset
`define IMU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu check failed");
// next-cycle implication
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu check failed");
`endif

FILE: src/imsc_pkg.sv
// shared types and constants for the imu sample converter
// no dependencies
`default_nettype none
package imsc_pkg;
  localparam int unsigned NumRegs = 7;
  localparam logic [2:0] RegGyroOffX  = 3'd0;
  localparam logic [2:0] RegGyroOffY  = 3'd1;
  localparam logic [2:0] RegGyroOffZ  = 3'd2;
  localparam logic [2:0] RegAccOffX   = 3'd3;
  localparam logic [2:0] RegAccOffY   = 3'd4;
  localparam logic [2:0] RegAccOffZ   = 3'd5;
  localparam logic [2:0] RegPeriod    = 3'd6;
  localparam logic [23:0] PeriodReset = 24'd16777;
  localparam logic signed [7:0]  GyroMul  = 8'sd70;
  localparam logic signed [15:0] AccelMul = 16'sd20072;
  localparam logic [12:0] GMul = 13'd6683;
  localparam logic signed [16:0] TempBias = 17'sd6400;

  // lane request: start and clear flag
  typedef struct packed {
    logic start;
    logic clr;
  } lane_ctl_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sd8388607;
    else if (v < -48'sd8388608) return -24'sd8388608;
    else return v[23:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/imsc_lane.sv
// one axis lane: offset, gyro and accel scaling, angle accumulator
// depends on imsc_pkg
`default_nettype none
module imsc_lane #(
  parameter int unsigned AccumWidth = 56,
  parameter bit Negate = 1'b1
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  imsc_pkg::lane_ctl_t      ctl_i,
  input  wire  logic [15:0]              gyro_word_i,
  input  wire  logic [15:0]              accel_word_i,
  input  wire  logic signed [23:0]       gyro_off_i,
  input  wire  logic signed [23:0]       accel_off_i,
  input  wire  logic [23:0]              period_i,
  output logic signed [23:0]             rate_o,
  output logic signed [23:0]             accel_o,
  output logic signed [31:0]             angle_o
);
  import imsc_pkg::*;
  localparam int unsigned AngW = AccumWidth - 24;

  logic signed [16:0] g_v, a_v;
  logic signed [25:0] cg, ca;
  logic signed [47:0] pg, pa;
  logic signed [23:0] rate_d, rate_q, accel_d, accel_q;
  logic signed [48:0] inc;
  logic signed [AccumWidth-1:0] acc_d, acc_q, base;
  logic signed [AngW-1:0] ang_hi;
  logic signed [63:0] ang_w;
  logic ph_q;
  logic clr_q;

  assign g_v = Negate ? -$signed({gyro_word_i[15], gyro_word_i})
                      : $signed({gyro_word_i[15], gyro_word_i});
  assign a_v = Negate ? -$signed({accel_word_i[15], accel_word_i})
                      : $signed({accel_word_i[15], accel_word_i});
  // +32768 * 256 minus the most negative offset needs 26 bits
  assign cg = 26'($signed({g_v, 8'd0})) - 26'(gyro_off_i);
  assign ca = 26'($signed({a_v, 8'd0})) - 26'(accel_off_i);
  assign pg = 48'(cg) * 48'(GyroMul) + 48'sd128;
  assign pa = 48'(ca) * 48'(AccelMul) + 48'sd32768;
  assign rate_d  = sat24(pg >>> 8);
  assign accel_d = sat24(pa >>> 16);
  assign inc = 49'(rate_q) * $signed({25'd0, period_i});
  assign base = clr_q ? '0 : acc_q;
  assign acc_d = base + AccumWidth'(inc);
  assign ang_hi = acc_q[AccumWidth-1:24];
  assign ang_w = 64'(ang_hi);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rate_q <= rate_d;
      accel_q <= accel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ph_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      ph_q <= ctl_i.start;
      if (ctl_i.start) clr_q <= ctl_i.clr;
      if (ph_q) acc_q <= acc_d;
    end
  end

  always_comb begin
    if (ang_w > 64'sd2147483647) angle_o = 32'sh7fffffff;
    else if (ang_w < -64'sd2147483648) angle_o = 32'sh80000000;
    else angle_o = 32'(ang_w);
  end
  assign rate_o = rate_q;
  assign accel_o = accel_q;
endmodule
`default_nettype wire

FILE: src/imsc_isqrt.sv
// iterative integer square root, one result bit per cycle
// depends on nothing
`default_nettype none
module imsc_isqrt (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start_i,
  input  wire  logic [49:0] x_i,
  output logic              done_o,
  output logic [24:0]       root_o
);
  logic [49:0] rem_q;
  logic [24:0] root_q;
  logic [4:0] cnt_q;
  logic busy_q;

  logic [49:0] x_q;
  logic [51:0] r2;
  logic [26:0] t;
  always_comb begin
    r2 = {rem_q, x_q[49:48]};
    t = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd24;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      root_q <= '0;
      x_q <= x_i;
    end else if (busy_q) begin
      x_q <= {x_q[47:0], 2'b00};
      if (r2 >= 52'(t)) begin
        rem_q <= 50'(r2 - 52'(t));
        root_q <= {root_q[23:0], 1'b1};
      end else begin
        rem_q <= 50'(r2);
        root_q <= {root_q[23:0], 1'b0};
      end
    end
  end
  assign root_o = root_q;
endmodule
`default_nettype wire

FILE: src/imsc_merge.sv
// merging stage: sum of squares, magnitude scaling, temperature
// depends on imsc_pkg, imsc_isqrt
`default_nettype none
module imsc_merge (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               start_i,
  input  wire  logic signed [23:0] ax_i,
  input  wire  logic signed [23:0] ay_i,
  input  wire  logic signed [23:0] az_i,
  input  wire  logic [15:0]        temp_word_i,
  output logic                     done_o,
  output logic [19:0]              mag_o,
  output logic signed [16:0]       temp_o
);
  import imsc_pkg::*;
  logic [1:0] step_q;
  logic [49:0] sum_q;
  logic signed [23:0] sel;
  logic [47:0] sq;
  logic sq_go, root_done;
  logic [24:0] root;
  logic [38:0] scaled;

  always_comb begin
    unique case (step_q)
      2'd0: sel = ax_i;
      2'd1: sel = ay_i;
      default: sel = az_i;
    endcase
  end
  assign sq = $unsigned(48'(sel) * 48'(sel));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sq_go <= 1'b0;
    end else begin
      sq_go <= 1'b0;
      if (start_i) step_q <= 2'd1;
      else if (step_q != 2'd0) begin
        step_q <= (step_q == 2'd3) ? 2'd0 : step_q + 2'd1;
        if (step_q == 2'd3) sq_go <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= 50'(sq);
      temp_o <= $signed({temp_word_i[15], temp_word_i}) + TempBias;
    end else if (step_q == 2'd1 || step_q == 2'd2) sum_q <= sum_q + 50'(sq);
  end

  imsc_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .x_i(sum_q), .done_o(root_done), .root_o(root)
  );

  assign scaled = 39'(root) * 39'(GMul) + 39'd32768;
  always_ff @(posedge clk_i) begin
    if (root_done) mag_o <= (scaled[38:16] > 23'd1048575) ? 20'hfffff : scaled[35:16];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= root_done;
  end
endmodule
`default_nettype wire

FILE: src/imu_sample_converter.sv
// top level of the imu sample converter: config registers, three lanes, merge
// depends on imsc_pkg, imsc_lane, imsc_merge
// One frame is taken per request. The lanes scale at the accept edge; the merging
// stage then sums the squared accel values of the three axes, starts the
// bit-serial square root (25 iterations), registers the magnitude scaling and
// then raises the output flag. The three axis lanes update their angle
// accumulators on the cycle after the accept. A new frame is accepted once the
// previous result has been taken from the output register.
`default_nettype none
module imu_sample_converter #(
  parameter int unsigned ACCUM_WIDTH = 56
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               cfg_we_i,
  input  wire  logic [2:0]         cfg_idx_i,
  input  wire  logic [23:0]        cfg_data_i,
  input  wire  logic               in_valid_i,
  output logic                     in_ready_o,
  input  wire  logic [15:0]        temp_word_i,
  input  wire  logic [15:0]        gyro_x_word_i,
  input  wire  logic [15:0]        gyro_y_word_i,
  input  wire  logic [15:0]        gyro_z_word_i,
  input  wire  logic [15:0]        accel_x_word_i,
  input  wire  logic [15:0]        accel_y_word_i,
  input  wire  logic [15:0]        accel_z_word_i,
  input  wire  logic               clear_angles_i,
  output logic                     out_valid_o,
  input  wire  logic               out_ready_i,
  output logic signed [23:0]       rate_x_o,
  output logic signed [23:0]       rate_y_o,
  output logic signed [23:0]       rate_z_o,
  output logic signed [23:0]       accel_x_o,
  output logic signed [23:0]       accel_y_o,
  output logic signed [23:0]       accel_z_o,
  output logic [19:0]              accel_magnitude_o,
  output logic signed [16:0]       temperature_o,
  output logic signed [31:0]       angle_x_o,
  output logic signed [31:0]       angle_y_o,
  output logic signed [31:0]       angle_z_o
);
  import imsc_pkg::*;

  logic signed [23:0] off_q [6];
  logic [23:0] period_q;
  logic busy_q;
  logic accept, done;
  lane_ctl_t ctl;
  logic signed [23:0] rate [3], acc [3];
  logic signed [31:0] ang [3];
  logic [19:0] mag;
  logic signed [16:0] temp;

  // config writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) off_q[i] <= '0;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegPeriod) period_q <= cfg_data_i;
      else if (cfg_idx_i <= RegAccOffZ) off_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // busy from accept until the result is taken
  assign in_ready_o = !busy_q;
  assign accept = in_valid_i && in_ready_o;
  assign ctl = '{start: accept, clr: clear_angles_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (accept) busy_q <= 1'b1;
      if (done) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
        busy_q <= 1'b0;
      end
    end
  end

  imsc_lane #(.AccumWidth(ACCUM_WIDTH), .Negate(1'b1)) u_lane_x (
    .clk_i, .rst_ni, .ctl_i(ctl), .gyro_word_i(gyro_x_word_i),
    .accel_word_i(accel_x_word_i), .gyro_off_i(off_q[RegGyroOffX]),
    .accel_off_i(off_q[RegAccOffX]), .period_i(period_q),
    .rate_o(rate[0]), .accel_o(acc[0]), .angle_o(ang[0])
  );
  imsc_lane #(.AccumWidth(ACCUM_WIDTH), .Negate(1'b1)) u_lane_y (
    .clk_i, .rst_ni, .ctl_i(ctl), .gyro_word_i(gyro_y_word_i),
    .accel_word_i(accel_y_word_i), .gyro_off_i(off_q[RegGyroOffY]),
    .accel_off_i(off_q[RegAccOffY]), .period_i(period_q),
    .rate_o(rate[1]), .accel_o(acc[1]), .angle_o(ang[1])
  );
  imsc_lane #(.AccumWidth(ACCUM_WIDTH), .Negate(1'b0)) u_lane_z (
    .clk_i, .rst_ni, .ctl_i(ctl), .gyro_word_i(gyro_z_word_i),
    .accel_word_i(accel_z_word_i), .gyro_off_i(off_q[RegGyroOffZ]),
    .accel_off_i(off_q[RegAccOffZ]), .period_i(period_q),
    .rate_o(rate[2]), .accel_o(acc[2]), .angle_o(ang[2])
  );

  // merge starts the cycle after accept, once lane accel registers hold
  logic merge_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) merge_go_q <= 1'b0;
    else merge_go_q <= accept;
  end
  logic [15:0] temp_word_q;
  always_ff @(posedge clk_i) begin
    if (accept) temp_word_q <= temp_word_i;
  end

  imsc_merge u_merge (
    .clk_i, .rst_ni, .start_i(merge_go_q), .ax_i(acc[0]), .ay_i(acc[1]),
    .az_i(acc[2]), .temp_word_i(temp_word_q), .done_o(done),
    .mag_o(mag), .temp_o(temp)
  );

  assign rate_x_o = rate[0];
  assign rate_y_o = rate[1];
  assign rate_z_o = rate[2];
  assign accel_x_o = acc[0];
  assign accel_y_o = acc[1];
  assign accel_z_o = acc[2];
  assign angle_x_o = ang[0];
  assign angle_y_o = ang[1];
  assign angle_z_o = ang[2];
  assign accel_magnitude_o = mag;
  assign temperature_o = temp;
endmodule
`default_nettype wire

FILE: src/imu_sample_converter_checker.sv
// port-level checks for the imu sample converter, bound to the top level
// depends on imu_sample_converter_defines.svh
`include "imu_sample_converter_defines.svh"
`default_nettype none
module imu_sample_converter_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [19:0] accel_magnitude_o
);
  `IMU_ASSERT_IMPL(no_ready_while_result, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `IMU_ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `IMU_ASSERT_NEXT(result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(accel_magnitude_o))
endmodule
bind imu_sample_converter imu_sample_converter_checker u_checker (.*);
`default_nettype wire
